// ----- rtl/core/accumulator_cpu_32_byte_defines.svh -----
// Assertion macros for the accumulator machine.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef ACCUMULATOR_CPU_32_BYTE_DEFINES_SVH
`define ACCUMULATOR_CPU_32_BYTE_DEFINES_SVH

// checked only outside reset
`define ACC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ACC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/acc32b_pkg.sv -----
// Shared constants and types for the accumulator machine.
// No dependencies.
package acc32b_pkg;

   localparam int MEM_WORDS_DEF = 32;
   localparam int INSTR_W       = 8;
   localparam int OPC_W         = 3;
   localparam int LIMIT_W       = 24;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 24'd65536;

   // register index of step_limit
   localparam logic [0:0] CSR_IDX_STEP_LIMIT = 1'b0;

   typedef enum logic [OPC_W-1:0] {
      OP_STA = 3'b000,
      OP_LDA = 3'b001,
      OP_BEQ = 3'b010,
      OP_NOP = 3'b011,
      OP_DEC = 3'b100,
      OP_INC = 3'b101,
      OP_JMP = 3'b110,
      OP_HLT = 3'b111
   } opcode_type;

endpackage

// ----- rtl/core/accumulator_cpu_32_byte.sv -----
// 8-bit accumulator machine with a 32-byte program memory, single module.
// Depends on acc32b_pkg and accumulator_cpu_32_byte_defines.svh.
//
// Program bytes are taken one per clock: each start transaction (start high
// while busy is low) writes the next memory address, 0 to 31 in turn. The
// transaction that carries the byte for address 31 launches a run from pc 0
// with accumulator 0 and raises busy. Every instruction passes a memory
// read (FETCH) and decode/execute (DECODE), LDA also a data read (LOAD),
// as program and data share one registered read port. The final fetch of
// HLT, or the fetch at which the step limit is met, passes through FETCH
// and DECODE; the result then sits on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, and busy drops in that same cycle. There is no
// back-pressure on the result side: the receiver must take the transaction
// when it is shown. step_limit (APB register 0, reset 65536) bounds the
// instructions of a run; reaching it reports the accumulator with
// rsp_timed_out set. A HLT found after exactly step_limit instructions still
// counts as a normal halt. STA writes survive the run until reloaded.
// Memory is not cleared at reset; every run follows 32 fresh writes.

`include "accumulator_cpu_32_byte_defines.svh"

module accumulator_cpu_32_byte
   import acc32b_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [INSTR_W-1:0]    req_program_byte,
   // result channel
   output logic                  rsp_valid,
   output logic [INSTR_W-1:0]    rsp_accumulator,
   output logic                  rsp_timed_out,
   // APB register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = $clog2(MEM_WORDS);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FETCH  = 2'd1;
   localparam logic [1:0] ST_DECODE = 2'd2;
   localparam logic [1:0] ST_LOAD   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  load_pos_ff, load_pos_in;
   logic [ADDR_W-1:0]  pc_ff, pc_in;
   logic [INSTR_W-1:0] acc_ff, acc_in;
   logic [LIMIT_W-1:0] step_ff, step_in;
   logic [LIMIT_W-1:0] step_limit_ff, step_limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INSTR_W-1:0] rsp_acc_ff, rsp_acc_in;
   logic               rsp_tmo_ff, rsp_tmo_in;

   // program/data memory, one write and one registered read per cycle
   logic [INSTR_W-1:0] mem [MEM_WORDS];
   logic [INSTR_W-1:0] mem_rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [INSTR_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   opcode_type         op;
   logic [ADDR_W-1:0]  opnd;
   logic               accept;
   logic               csr_wr;
   logic               csr_hit;

   assign op     = opcode_type'(mem_rdata_ff[INSTR_W-1 -: OPC_W]);
   assign opnd   = mem_rdata_ff[ADDR_W-1:0];
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // ---- register port ----
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_W-1] == CSR_IDX_STEP_LIMIT);
   assign csr_wr  = psel && penable && pwrite && csr_hit;

   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, step_limit_ff};
      end
   end

   always_comb begin
      step_limit_in = step_limit_ff;
      if (csr_wr) begin
         step_limit_in = pwdata[LIMIT_W-1:0];
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_acc_in   = rsp_acc_ff;
      rsp_tmo_in   = rsp_tmo_ff;
      mem_we       = 1'b0;
      mem_waddr    = load_pos_ff;
      mem_wdata    = req_program_byte;
      mem_raddr    = pc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mem_we      = 1'b1;
               load_pos_in = load_pos_ff + 1'b1;
               if (load_pos_ff == ADDR_W'(MEM_WORDS - 1)) begin
                  // last byte: fresh run from pc 0
                  pc_in    = '0;
                  acc_in   = '0;
                  step_in  = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            mem_raddr = pc_ff;
            state_in  = ST_DECODE;
         end
         ST_DECODE: begin
            if (op == OP_HLT) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_tmo_in   = 1'b0;
               state_in     = ST_IDLE;
            end else if (step_ff >= step_limit_ff) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_tmo_in   = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_FETCH;
               unique case (op)
                  OP_STA: begin
                     mem_we    = 1'b1;
                     mem_waddr = opnd;
                     mem_wdata = acc_ff;
                  end
                  OP_LDA: begin
                     mem_raddr = opnd;
                     state_in  = ST_LOAD;
                  end
                  OP_BEQ: begin
                     if (acc_ff == '0) begin
                        pc_in = opnd;
                     end
                  end
                  OP_DEC:  acc_in = acc_ff - 1'b1;
                  OP_INC:  acc_in = acc_ff + 1'b1;
                  OP_JMP:  pc_in  = opnd;
                  default: ; // NOP, HLT handled above
               endcase
            end
         end
         ST_LOAD: begin
            acc_in   = mem_rdata_ff;
            state_in = ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_pos_ff   <= '0;
         pc_ff         <= '0;
         acc_ff        <= '0;
         step_ff       <= '0;
         step_limit_ff <= STEP_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_pos_ff   <= load_pos_in;
         pc_ff         <= pc_in;
         acc_ff        <= acc_in;
         step_ff       <= step_in;
         step_limit_ff <= step_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_acc_ff <= rsp_acc_in;
      rsp_tmo_ff <= rsp_tmo_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accumulator = rsp_acc_ff;
   assign rsp_timed_out   = rsp_tmo_ff;

   // ---- assertions ----
   `ACC_ASSERT(a_rsp_from_decode, rsp_valid |-> ($past(state_ff) == ST_DECODE && !busy), "result not issued from decode")
   `ACC_ASSERT(a_last_byte_runs, (accept && load_pos_ff == ADDR_W'(MEM_WORDS - 1)) |=> (state_ff == ST_FETCH && pc_ff == '0), "run did not start after last byte")
   `ACC_ASSERT(a_timeout_at_limit, (rsp_valid && rsp_timed_out) |-> (step_ff == step_limit_ff), "timeout reported below step limit")
   `ACC_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> (!rsp_valid && !busy), "activity right after reset")

endmodule
